// File: sv/multi_channel_timeout_monitor_unit_assert.svh
// Assertion macros used by the top-level file of the timeout monitor.
`ifndef MULTI_CHANNEL_TIMEOUT_MONITOR_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_TIMEOUT_MONITOR_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MCTM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("timeout monitor invariant violated");

// A condition that must be followed by another in the next cycle.
`define MCTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timeout monitor sequencing violated");

`endif

// File: sv/mctm_pkg.sv
`default_nettype none
package mctm_pkg;

  // Fixed field widths of the block's ports.
  localparam int CMD_W     = 2;
  localparam int CHAN_W    = 3;
  localparam int TIMEOUT_W = 16;
  localparam int FLAG_W    = 8;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;

  // Reset timeout of each channel, in milliseconds.
  localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUTS [NUM_REGS] = '{
    16'd1000, 16'd1000, 16'd1000, 16'd400, 16'd500, 16'd200, 16'd400, 16'd5000
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_KICK = 2'd1,
    CMD_SCAN = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } dp_ctrl_t;

endpackage
`default_nettype wire

// File: sv/mctm_ctrl.sv
`default_nettype none
module mctm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output mctm_pkg::dp_ctrl_t     ctrl,
  output logic                   busy,
  output logic                   done
);

  mctm_pkg::state_t state;
  mctm_pkg::state_t state_next;
  logic             accept;

  assign accept = start && (state != mctm_pkg::ST_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mctm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mctm_pkg::ST_IDLE: begin
        if (accept) state_next = mctm_pkg::ST_EXEC;
      end
      mctm_pkg::ST_EXEC: begin
        state_next = mctm_pkg::ST_DONE;
      end
      mctm_pkg::ST_DONE: begin
        if (accept) state_next = mctm_pkg::ST_EXEC;
        else        state_next = mctm_pkg::ST_IDLE;
      end
      default: begin
        state_next = mctm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    done      = 1'b0;
    ctrl.load = 1'b0;
    ctrl.exec = 1'b0;
    unique case (state)
      mctm_pkg::ST_IDLE: begin
        ctrl.load = start;
      end
      mctm_pkg::ST_EXEC: begin
        busy      = 1'b1;
        ctrl.exec = 1'b1;
      end
      mctm_pkg::ST_DONE: begin
        done      = 1'b1;
        ctrl.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/mctm_datapath.sv
`default_nettype none
module mctm_datapath #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mctm_pkg::dp_ctrl_t                 ctrl,
  input  wire logic [mctm_pkg::CMD_W-1:0]         cmd,
  input  wire logic [mctm_pkg::CHAN_W-1:0]        channel,
  input  wire logic                               cfg_we,
  input  wire logic [mctm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mctm_pkg::TIMEOUT_W-1:0]     cfg_data,
  output logic      [mctm_pkg::FLAG_W-1:0]        overtime_flags,
  output logic      [mctm_pkg::FLAG_W-1:0]        lost_flags,
  output logic                                    any_overtime
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [mctm_pkg::CMD_W-1:0]     cmd_q;
  logic [mctm_pkg::CHAN_W-1:0]    channel_q;
  logic [mctm_pkg::TIMEOUT_W-1:0] timeout   [CHANNELS];
  logic [TIME_BITS-1:0]           time_now;
  logic [TIME_BITS-1:0]           kick_stamp [CHANNELS];
  logic [CHANNELS-1:0]            lost_flag;
  logic [CHANNELS-1:0]            overtime_flag;
  logic                           any_timeout;
  logic [CHANNELS-1:0]            timed_out;
  logic                           kick_ok;
  logic                           cfg_ok;

  assign kick_ok = (32'(channel_q) < CHANNELS);
  assign cfg_ok  = (32'(cfg_index) < CHANNELS);

  // One subtract and compare per channel; the subtraction wraps at TIME_BITS.
  always_comb begin
    logic [TIME_BITS-1:0] elapsed;
    timed_out = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed      = time_now - kick_stamp[i];
      timed_out[i] = elapsed > TIME_BITS'(timeout[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q     <= cmd;
      channel_q <= channel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        timeout[i] <= mctm_pkg::RESET_TIMEOUTS[i];
      end
    end else if (cfg_we && cfg_ok) begin
      timeout[cfg_index[CH_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now      <= '0;
      lost_flag     <= '1;
      overtime_flag <= '1;
      any_timeout   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        kick_stamp[i] <= '0;
      end
    end else if (ctrl.exec) begin
      case (mctm_pkg::cmd_t'(cmd_q))
        mctm_pkg::CMD_TICK: begin
          time_now <= time_now + TIME_BITS'(1);
        end
        mctm_pkg::CMD_KICK: begin
          if (kick_ok) begin
            kick_stamp[channel_q[CH_IDX_W-1:0]] <= time_now;
            lost_flag[channel_q[CH_IDX_W-1:0]]  <= 1'b0;
          end
        end
        mctm_pkg::CMD_SCAN: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (timed_out[i]) begin
              if (!overtime_flag[i]) begin
                lost_flag[i]     <= 1'b1;
                overtime_flag[i] <= 1'b1;
              end
            end else begin
              lost_flag[i]     <= 1'b0;
              overtime_flag[i] <= 1'b0;
            end
          end
          any_timeout <= |timed_out;
        end
        default: begin
          any_timeout <= any_timeout;
        end
      endcase
    end
  end

  always_comb begin
    overtime_flags = '0;
    lost_flags     = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      overtime_flags[i] = overtime_flag[i];
      lost_flags[i]     = lost_flag[i];
    end
    any_overtime = any_timeout;
  end

endmodule
`default_nettype wire

// File: sv/multi_channel_timeout_monitor_unit.sv
`default_nettype none
// Eight-channel software-style watchdog. A command beat is taken when start is
// high and busy is low; it is a one-millisecond tick, a kick of one channel or
// a scan of all channels, and the spare code changes nothing. The controller
// latches the command on acceptance, the datapath applies it in the execute
// state, and then done is high for exactly one cycle with the channel flags
// on the result ports. The receiver cannot stall, so the result must be
// captured in that cycle. A new command may be presented in the cycle that
// done is high; none is taken while the controller is in its execute state.
// Timeouts are written through the configuration channel, which is always
// ready; write them only while the block is idle.
module multi_channel_timeout_monitor_unit #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [mctm_pkg::CMD_W-1:0]         cmd,
  input  wire logic [mctm_pkg::CHAN_W-1:0]        channel,
  output logic                                    done,
  output logic      [mctm_pkg::FLAG_W-1:0]        overtime_flags,
  output logic      [mctm_pkg::FLAG_W-1:0]        lost_flags,
  output logic                                    any_overtime,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mctm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mctm_pkg::TIMEOUT_W-1:0]     cfg_data
);

  mctm_pkg::dp_ctrl_t ctrl;

  // Register writes never wait; indexes outside the channel bank are dropped.
  assign cfg_ready = 1'b1;

  // The controller sequences each command through a latch and an execute cycle.
  mctm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the counter, kick stamps, flags and timeout registers,
  // and compares every channel in parallel during a scan.
  mctm_datapath #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cmd            (cmd),
    .channel        (channel),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .overtime_flags (overtime_flags),
    .lost_flags     (lost_flags),
    .any_overtime   (any_overtime)
  );

  `include "multi_channel_timeout_monitor_unit_assert.svh"

  // An accepted beat always moves into the execute cycle.
  `MCTM_ASSERT_NEXT(a_accept_exec, start && !busy, busy)
  // The execute cycle is always followed by the result strobe.
  `MCTM_ASSERT_NEXT(a_exec_done, busy, done && !busy)
  // A lost flag is only ever set together with its overtime flag.
  `MCTM_ASSERT_ALWAYS(a_lost_within_overtime, (lost_flags & ~overtime_flags) == '0)
  // The aggregate flag implies at least one channel is overtime.
  `MCTM_ASSERT_ALWAYS(a_any_has_channel, !any_overtime || (overtime_flags != '0))

endmodule
`default_nettype wire

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default channel count and counter width, and
  // the prediction below follows the same sizes.
  localparam int CHANNELS  = 8;
  localparam int TIME_BITS = 32;

  // The command field is two bits wide, so one code is left over. The block
  // must treat it as a beat that changes nothing but still reports the flags.
  localparam logic [mctm_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  // Cycles without any accepted beat, written register or result before the
  // run is declared hung. The slowest correct beat needs the longest idle gap
  // of the sender plus its execution, so this is many times the worst case.
  localparam int HANG_LIMIT = 500;

  typedef logic [mctm_pkg::TIMEOUT_W-1:0] timeout_bank_t [mctm_pkg::NUM_REGS];

  // Timeout programmes used between phases of the random part.
  typedef enum {
    SET_TIGHT,
    SET_EXTREME,
    SET_LOOSE,
    SET_WIDE
  } timeout_setting_t;

  // Timeouts for the directed part: zero, the maximum, and a few small values
  // that a handful of ticks can exceed.
  localparam timeout_bank_t DIRECTED_TIMEOUTS = '{
    16'd0, 16'hFFFF, 16'd2, 16'd1, 16'd5, 16'd0, 16'd3, 16'hFFFF
  };

  typedef struct packed {
    logic [mctm_pkg::FLAG_W-1:0] overtime;
    logic [mctm_pkg::FLAG_W-1:0] lost;
    logic                        any_overtime;
  } flag_report_t;

  // Keeps a private copy of the watchdog bank, works out the flag report that
  // each accepted command beat must produce, and checks reports as they come.
  class watchdog_scoreboard;
    logic [mctm_pkg::TIMEOUT_W-1:0] timeouts [mctm_pkg::NUM_REGS];
    logic [TIME_BITS-1:0]           time_now;
    logic [TIME_BITS-1:0]           kick_stamp [mctm_pkg::NUM_REGS];
    logic [mctm_pkg::FLAG_W-1:0]    lost;
    logic [mctm_pkg::FLAG_W-1:0]    overtime;
    logic                           any_timeout;
    flag_report_t                   due_reports [$];
    int                             errors;

    function new();
      for (int i = 0; i < mctm_pkg::NUM_REGS; i++) begin
        timeouts[i]   = mctm_pkg::RESET_TIMEOUTS[i];
        kick_stamp[i] = '0;
      end
      time_now    = '0;
      lost        = '1;
      overtime    = '1;
      any_timeout = 1'b0;
      errors      = 0;
    endfunction

    function void write_timeout(logic [mctm_pkg::CFG_IDX_W-1:0] idx,
                                logic [mctm_pkg::TIMEOUT_W-1:0] value);
      if (idx < mctm_pkg::NUM_REGS)
        timeouts[idx] = value;
    endfunction

    function void note_command(logic [mctm_pkg::CMD_W-1:0] code,
                               logic [mctm_pkg::CHAN_W-1:0] ch);
      logic [TIME_BITS-1:0] elapsed;
      logic                 hit;
      flag_report_t         report;
      case (code)
        mctm_pkg::CMD_TICK: time_now = time_now + 1'b1;
        mctm_pkg::CMD_KICK: begin
          if (ch < CHANNELS) begin
            kick_stamp[ch] = time_now;
            lost[ch]       = 1'b0;
          end
        end
        mctm_pkg::CMD_SCAN: begin
          hit = 1'b0;
          for (int i = 0; i < CHANNELS; i++) begin
            elapsed = time_now - kick_stamp[i];
            if (elapsed > TIME_BITS'(timeouts[i])) begin
              if (!overtime[i]) begin
                lost[i]     = 1'b1;
                overtime[i] = 1'b1;
              end
              hit = 1'b1;
            end else begin
              lost[i]     = 1'b0;
              overtime[i] = 1'b0;
            end
          end
          any_timeout = hit;
        end
        default: ;
      endcase
      report.overtime     = overtime;
      report.lost         = lost;
      report.any_overtime = any_timeout;
      due_reports.push_back(report);
    endfunction

    function void check_result(logic [mctm_pkg::FLAG_W-1:0] ot,
                               logic [mctm_pkg::FLAG_W-1:0] lo, logic any_ot);
      flag_report_t due;
      if (due_reports.size() == 0) begin
        $error("flag report arrived with no command beat outstanding");
        errors++;
        return;
      end
      due = due_reports.pop_front();
      if (ot !== due.overtime) begin
        $error("overtime_flags: expected %h, got %h", due.overtime, ot);
        errors++;
      end
      if (lo !== due.lost) begin
        $error("lost_flags: expected %h, got %h", due.lost, lo);
        errors++;
      end
      if (any_ot !== due.any_overtime) begin
        $error("any_overtime: expected %b, got %b", due.any_overtime, any_ot);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_reports.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           start     = 1'b0;
  logic [mctm_pkg::CMD_W-1:0]     cmd       = mctm_pkg::CMD_TICK;
  logic [mctm_pkg::CHAN_W-1:0]    channel   = '0;
  logic                           cfg_valid = 1'b0;
  logic [mctm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mctm_pkg::TIMEOUT_W-1:0] cfg_data  = '0;
  logic                           busy;
  logic                           done;
  logic [mctm_pkg::FLAG_W-1:0]    overtime_flags;
  logic [mctm_pkg::FLAG_W-1:0]    lost_flags;
  logic                           any_overtime;
  logic                           cfg_ready;

  int                             hang_count = 0;
  watchdog_scoreboard             board = new();

  multi_channel_timeout_monitor_unit #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .channel        (channel),
    .done           (done),
    .overtime_flags (overtime_flags),
    .lost_flags     (lost_flags),
    .any_overtime   (any_overtime),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Every report is present for a single cycle and cannot be held off, so it
  // is sampled at the edge that closes the cycle in which done is high.
  always @(posedge clk) begin
    if (!rst && done)
      board.check_result(overtime_flags, lost_flags, any_overtime);
  end

  // Hang detector: any accepted command beat, register write or report counts
  // as progress and restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      hang_count <= 0;
    else
      hang_count <= hang_count + 1;
    if (hang_count >= HANG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Presents one command beat and returns at the edge that accepts it. Start
  // is left high, so a following beat can go out back to back; it is only
  // lowered by an idle gap or at the end of a phase.
  task automatic send_command(logic [mctm_pkg::CMD_W-1:0] code,
                              logic [mctm_pkg::CHAN_W-1:0] ch);
    start   <= 1'b1;
    cmd     <= code;
    channel <= ch;
    do @(posedge clk); while (busy);
    board.note_command(code, ch);
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    repeat ($urandom_range(1, 11)) @(posedge clk);
  endtask

  // Waits until every report owed by the block has been seen. As each beat
  // yields exactly one report, the block is then idle.
  task automatic drain_reports();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Writes all eight timeouts, then one index beyond the register list, which
  // the block must ignore. Valid stays high across consecutive writes.
  task automatic program_timeouts(timeout_bank_t values);
    logic [mctm_pkg::CFG_IDX_W-1:0] stray_idx;
    logic [mctm_pkg::TIMEOUT_W-1:0] stray_val;
    stray_idx = mctm_pkg::CFG_IDX_W'($urandom_range(mctm_pkg::NUM_REGS,
                                                    (1 << mctm_pkg::CFG_IDX_W) - 1));
    stray_val = mctm_pkg::TIMEOUT_W'($urandom);
    for (int i = 0; i <= mctm_pkg::NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i < mctm_pkg::NUM_REGS) ? mctm_pkg::CFG_IDX_W'(i) : stray_idx;
      cfg_data  <= (i < mctm_pkg::NUM_REGS) ? values[i] : stray_val;
      do @(posedge clk); while (!cfg_ready);
      board.write_timeout((i < mctm_pkg::NUM_REGS) ? mctm_pkg::CFG_IDX_W'(i) : stray_idx,
                          (i < mctm_pkg::NUM_REGS) ? values[i] : stray_val);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic timeout_bank_t pick_timeouts(timeout_setting_t setting);
    timeout_bank_t bank;
    for (int i = 0; i < mctm_pkg::NUM_REGS; i++) begin
      case (setting)
        SET_TIGHT:   bank[i] = mctm_pkg::TIMEOUT_W'($urandom_range(0, 12));
        SET_EXTREME: bank[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        SET_LOOSE:   bank[i] = mctm_pkg::TIMEOUT_W'($urandom_range(0, 40));
        default:     bank[i] = mctm_pkg::TIMEOUT_W'($urandom);
      endcase
    end
    return bank;
  endfunction

  // Mostly ticks, kicks and scans in proportions that let channels drift past
  // their limits and be rescued; a few spare codes are mixed in as noise.
  task automatic send_random_command();
    int                          roll;
    logic [mctm_pkg::CMD_W-1:0]  code;
    roll = $urandom_range(0, 99);
    if (roll < 45)
      code = mctm_pkg::CMD_TICK;
    else if (roll < 75)
      code = mctm_pkg::CMD_KICK;
    else if (roll < 95)
      code = mctm_pkg::CMD_SCAN;
    else
      code = CMD_SPARE;
    send_command(code, mctm_pkg::CHAN_W'($urandom_range(0, 7)));
  endtask

  initial begin
    timeout_setting_t phase_plan [7];
    phase_plan = '{SET_TIGHT, SET_EXTREME, SET_LOOSE, SET_WIDE,
                   SET_TIGHT, SET_EXTREME, SET_TIGHT};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Before any scan the per-channel flags must read their
    // reset value of all ones, but for the lost flag that a kick clears, while
    // the aggregate flag reads zero; the spare code must leave everything alone.
    send_command(CMD_SPARE, 3'd7);
    send_command(mctm_pkg::CMD_TICK, 3'd0);
    send_command(mctm_pkg::CMD_KICK, 3'd7);
    // A scan with the reset timeouts and almost no elapsed time clears all.
    send_command(mctm_pkg::CMD_SCAN, 3'd0);
    drain_reports();

    program_timeouts(DIRECTED_TIMEOUTS);
    // Four ticks push timeouts of three or less over their limits, while those
    // of five and the maximum stay within. Channel fields here must be ignored.
    repeat (4) send_command(mctm_pkg::CMD_TICK, 3'd5);
    send_command(mctm_pkg::CMD_SCAN, 3'd6);
    // A kick on a channel that is still overtime clears only its lost flag;
    // the next scan finds it timed out again and must leave that flag clear.
    send_command(mctm_pkg::CMD_KICK, 3'd0);
    send_command(mctm_pkg::CMD_TICK, 3'd2);
    send_command(mctm_pkg::CMD_SCAN, 3'd1);
    // Kicking all the other channels and scanning at once brings them back.
    for (int ch = 1; ch < mctm_pkg::NUM_REGS; ch++)
      send_command(mctm_pkg::CMD_KICK, mctm_pkg::CHAN_W'(ch));
    send_command(mctm_pkg::CMD_SCAN, 3'd7);
    send_command(CMD_SPARE, 3'd0);
    drain_reports();

    // Random part, in phases with a fresh timeout programme each. Idle gaps
    // on the sender side fall at random, except in the final phase, which
    // runs flat out.
    foreach (phase_plan[p]) begin
      program_timeouts(pick_timeouts(phase_plan[p]));
      for (int n = 0; n < 230; n++) begin
        if (p != $size(phase_plan) - 1 && $urandom_range(0, 5) == 0)
          pause_sender();
        send_random_command();
      end
      drain_reports();
    end

    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
